### design/lcpr_pkg.sv
// Shared types, constants and codes for the LED cube PWM refresh engine.
package lcpr_pkg;

    // Cube geometry and driver chain
    localparam int CUBE_SIDE     = 8;
    localparam int CHAIN_MODULES = 8;
    localparam int COORD_W       = 3;
    localparam int STORE_DEPTH   = 512;
    localparam int STORE_AW      = 9;
    localparam int MOD_W         = (CHAIN_MODULES > 1) ? $clog2(CHAIN_MODULES) : 1;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // Driver register addresses and set-up data
    localparam logic [3:0] ADDR_FIRST_SETUP = 4'h9;
    localparam logic [7:0] NORMAL_OPERATION = 8'h01;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD  = 3'd3;

    // Configuration reset values
    localparam logic [7:0] DECODE_MODE_RST = 8'h00;
    localparam logic [3:0] INTENSITY_RST   = 4'h9;
    localparam logic [7:0] SCAN_LIMIT_RST  = 8'h0F;
    localparam logic [7:0] PWM_PERIOD_RST  = 8'd10;

    // Result kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_REFRESH = 2'd2,
        OP_INIT    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_PUT,
        ST_REF_READ,
        ST_REF_DRAIN,
        ST_REF_EMIT,
        ST_INIT_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] decode_mode;
        logic [3:0] intensity;
        logic [7:0] scan_limit;
        logic [7:0] pwm_period;
    } cfg_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic [STORE_AW-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic               en;
        logic [COORD_W-1:0] col;
    } acc_ctl_t;

endpackage

### design/lcpr_level_mem.sv
// Brightness level store: one write port, one registered read port.
module lcpr_level_mem (
    input  logic                 aclk,
    input  lcpr_pkg::mem_req_t   req,
    output logic [7:0]           rd_level
);

    logic [7:0] mem [lcpr_pkg::STORE_DEPTH];
    logic [7:0] rd_data_reg;

    // Write and read the array, read data registered
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_level = rd_data_reg;

endmodule

### design/lcpr_bit_acc.sv
// Shared phase comparator that builds one command data byte a column at a time.
module lcpr_bit_acc (
    input  logic                aclk,
    input  lcpr_pkg::acc_ctl_t  ctl,
    input  logic [7:0]          phase,
    input  logic [7:0]          level,
    output logic [7:0]          bits
);

    logic [7:0] bits_reg;

    // Light the column when the phase is below its level
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            bits_reg[ctl.col] <= (phase < level);
        end
    end

    assign bits = bits_reg;

endmodule

### design/lcpr_seq.sv
// Sequencer: input capture, store clearing, refresh and init word generation, output register.
module lcpr_seq (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [1:0]                         s_tuser,
    input  logic [lcpr_pkg::S_TDATA_W-1:0]     s_tdata,
    input  lcpr_pkg::cfg_t                     cfg,
    output lcpr_pkg::mem_req_t                 mem_req,
    input  logic [7:0]                         rd_level,
    output lcpr_pkg::acc_ctl_t                 acc_ctl,
    input  logic [7:0]                         acc_bits,
    output logic [7:0]                         phase,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lcpr_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    lcpr_pkg::state_t state_reg, state_next;

    logic [lcpr_pkg::STORE_AW-1:0] clr_reg, clr_next;
    logic [lcpr_pkg::COORD_W-1:0]  x_reg, x_next;
    logic [lcpr_pkg::COORD_W-1:0]  y_reg, y_next;
    logic [lcpr_pkg::COORD_W-1:0]  z_reg, z_next;
    logic [lcpr_pkg::COORD_W-1:0]  row_reg, row_next;
    logic [lcpr_pkg::MOD_W-1:0]    mod_reg, mod_next;
    logic [lcpr_pkg::COORD_W-1:0]  col_reg, col_next;
    logic [7:0]                    phase_reg, phase_next;
    logic                          cmp_en_reg, cmp_en_next;
    logic [lcpr_pkg::COORD_W-1:0]  cmp_col_reg;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [3:0] m_addr_reg;
    logic [7:0] m_data_reg;
    logic       m_fend_reg, m_lit_reg, m_kind_reg, m_last_reg;

    logic                         in_accept;
    lcpr_pkg::op_t                in_op;
    logic [lcpr_pkg::COORD_W-1:0] in_x, in_y, in_z;
    logic [7:0]                   in_level;
    logic                         out_free;
    logic                         mod_last, row_last;
    logic [lcpr_pkg::COORD_W-1:0] dep;
    logic [8:0]                   phase_inc;

    logic       out_load;
    logic [3:0] out_addr;
    logic [7:0] out_data;
    logic       out_fend, out_lit, out_kind, out_last;

    // Unpack the input transaction
    assign in_op    = lcpr_pkg::op_t'(s_tuser);
    assign in_x     = s_tdata[2:0];
    assign in_y     = s_tdata[5:3];
    assign in_z     = s_tdata[8:6];
    assign in_level = s_tdata[16:9];

    assign s_tready  = (state_reg == lcpr_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign mod_last  = (mod_reg == lcpr_pkg::MOD_W'(lcpr_pkg::CHAIN_MODULES - 1));
    assign dep       = lcpr_pkg::COORD_W'(lcpr_pkg::CHAIN_MODULES - 1)
                       - lcpr_pkg::COORD_W'(mod_reg);
    assign phase_inc = {1'b0, phase_reg} + 9'd1;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lcpr_pkg::ST_CLEAR: begin
                if (clr_reg == '1) state_next = lcpr_pkg::ST_IDLE;
            end
            lcpr_pkg::ST_IDLE: begin
                if (in_accept) begin
                    case (in_op)
                        lcpr_pkg::OP_READ:    state_next = lcpr_pkg::ST_READ_PUT;
                        lcpr_pkg::OP_REFRESH: state_next = lcpr_pkg::ST_REF_READ;
                        lcpr_pkg::OP_INIT:    state_next = lcpr_pkg::ST_INIT_EMIT;
                        default:              state_next = lcpr_pkg::ST_IDLE;
                    endcase
                end
            end
            lcpr_pkg::ST_READ_PUT: begin
                if (out_free) state_next = lcpr_pkg::ST_IDLE;
            end
            lcpr_pkg::ST_REF_READ: begin
                if (col_reg == '1) state_next = lcpr_pkg::ST_REF_DRAIN;
            end
            lcpr_pkg::ST_REF_DRAIN: begin
                state_next = lcpr_pkg::ST_REF_EMIT;
            end
            lcpr_pkg::ST_REF_EMIT: begin
                if (out_free) begin
                    state_next = (row_reg == 3'd7 && mod_last) ? lcpr_pkg::ST_IDLE
                                                               : lcpr_pkg::ST_REF_READ;
                end
            end
            lcpr_pkg::ST_INIT_EMIT: begin
                if (out_free && row_reg == 3'd3 && mod_last) state_next = lcpr_pkg::ST_IDLE;
            end
            default: state_next = lcpr_pkg::ST_CLEAR;
        endcase
    end

    // Outputs and counter updates
    always_comb begin
        clr_next    = clr_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        row_next    = row_reg;
        mod_next    = mod_reg;
        col_next    = col_reg;
        phase_next  = phase_reg;
        cmp_en_next = 1'b0;
        mem_req     = '{we: 1'b0, waddr: {x_reg, y_reg, z_reg}, wdata: in_level,
                        raddr: {x_reg, y_reg, z_reg}};
        out_load    = 1'b0;
        out_addr    = '0;
        out_data    = '0;
        out_fend    = 1'b0;
        out_lit     = 1'b0;
        out_kind    = lcpr_pkg::KIND_CMD;
        out_last    = 1'b0;
        row_last    = 1'b0;
        case (state_reg)
            lcpr_pkg::ST_CLEAR: begin
                // Sweep zeros through the store
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                mem_req.wdata = '0;
                clr_next      = clr_reg + 1'b1;
            end
            lcpr_pkg::ST_IDLE: begin
                // Write directly; start the read for a read request
                mem_req.waddr = {in_x, in_y, in_z};
                mem_req.raddr = {in_x, in_y, in_z};
                mem_req.we    = in_accept && (in_op == lcpr_pkg::OP_WRITE);
                if (in_accept) begin
                    x_next   = in_x;
                    y_next   = in_y;
                    z_next   = in_z;
                    row_next = '0;
                    mod_next = '0;
                    col_next = '0;
                end
            end
            lcpr_pkg::ST_READ_PUT: begin
                // Hold the read address so the registered data stays put
                out_load = out_free;
                out_kind = lcpr_pkg::KIND_READ;
                out_lit  = (rd_level != 8'd0);
                out_last = 1'b1;
            end
            lcpr_pkg::ST_REF_READ: begin
                // Issue one column read per cycle; the compare follows in the next cycle
                mem_req.raddr = {dep, row_reg, col_reg};
                cmp_en_next   = 1'b1;
                col_next      = col_reg + 1'b1;
            end
            lcpr_pkg::ST_REF_DRAIN: begin
                mem_req.raddr = {dep, row_reg, col_reg};
            end
            lcpr_pkg::ST_REF_EMIT: begin
                row_last = (row_reg == 3'd7) && mod_last;
                out_load = out_free;
                out_addr = {1'b0, row_reg} + 4'd1;
                out_data = acc_bits;
                out_fend = mod_last;
                out_last = row_last;
                if (out_free) begin
                    // Advance module, then row; advance the phase after the last word, wrapping at the period
                    if (mod_last) begin
                        mod_next = '0;
                        row_next = row_reg + 1'b1;
                    end else begin
                        mod_next = mod_reg + 1'b1;
                    end
                    if (row_last) begin
                        phase_next = (phase_inc >= {1'b0, cfg.pwm_period}) ? 8'd0
                                                                           : phase_inc[7:0];
                    end
                end
            end
            lcpr_pkg::ST_INIT_EMIT: begin
                out_load = out_free;
                out_addr = lcpr_pkg::ADDR_FIRST_SETUP + {2'b00, row_reg[1:0]};
                case (row_reg[1:0])
                    2'd0:    out_data = cfg.decode_mode;
                    2'd1:    out_data = {4'h0, cfg.intensity};
                    2'd2:    out_data = cfg.scan_limit;
                    default: out_data = lcpr_pkg::NORMAL_OPERATION;
                endcase
                out_fend = mod_last;
                out_last = (row_reg == 3'd3) && mod_last;
                if (out_free) begin
                    if (mod_last) begin
                        mod_next = '0;
                        row_next = row_reg + 1'b1;
                    end else begin
                        mod_next = mod_reg + 1'b1;
                    end
                end
            end
            default: begin
                clr_next = '0;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lcpr_pkg::ST_CLEAR;
            clr_reg      <= '0;
            row_reg      <= '0;
            mod_reg      <= '0;
            col_reg      <= '0;
            phase_reg    <= '0;
            cmp_en_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            row_reg      <= row_next;
            mod_reg      <= mod_next;
            col_reg      <= col_next;
            phase_reg    <= phase_next;
            cmp_en_reg   <= cmp_en_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        cmp_col_reg <= col_reg;
        if (out_load) begin
            m_addr_reg <= out_addr;
            m_data_reg <= out_data;
            m_fend_reg <= out_fend;
            m_lit_reg  <= out_lit;
            m_kind_reg <= out_kind;
            m_last_reg <= out_last;
        end
    end

    assign acc_ctl  = '{en: cmp_en_reg, col: cmp_col_reg};
    assign phase    = phase_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_lit_reg, m_fend_reg, m_data_reg, m_addr_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

### design/led_cube_pwm_refresh.sv
// Top level of the LED cube PWM refresh engine.
//
// Input stream (s_): one transaction per request; s_tuser carries the op
// (write level, read, refresh, init). A write stores one 8-bit level and
// returns nothing. A read returns one answer transaction (m_tuser = 1) that
// says whether the stored level is nonzero. A refresh returns 64 command
// words for the driver chain, row by row, last module first, each bit lit
// where the PWM phase is below the level; the phase then advances and wraps
// at pwm_period. An init returns 32 set-up words (four groups of eight).
// Output stream (m_): m_tlast marks the last result of a request; frame_end
// in m_tdata marks the eighth word of each group, after which to latch.
// A refresh word is built from 8 level reads through the single memory read
// port and the shared comparator, then a drain step and an emit. One request
// is worked at a time. Reset clears the configuration, phase and output
// register, then a clearing pass zeroes all 512 entries of the level store;
// s_tready stays low until it finishes. Configuration writes are taken at
// any time. When the receiver stalls, the result holds in the output
// register and the sequencer waits.
module led_cube_pwm_refresh (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [2:0] depth_index, [5:3] row_index, [8:6] column_index, [16:9] level
    input  logic [lcpr_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] op
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] reg_address, [11:4] reg_data, [12] frame_end, [13] is_lit
    output logic [lcpr_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] kind
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_wen,
    input  logic [lcpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcpr_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

    lcpr_pkg::cfg_t     cfg_reg;
    lcpr_pkg::mem_req_t mem_req;
    lcpr_pkg::acc_ctl_t acc_ctl;
    logic [7:0]         rd_level;
    logic [7:0]         acc_bits;
    logic [7:0]         phase;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.decode_mode <= lcpr_pkg::DECODE_MODE_RST;
            cfg_reg.intensity   <= lcpr_pkg::INTENSITY_RST;
            cfg_reg.scan_limit  <= lcpr_pkg::SCAN_LIMIT_RST;
            cfg_reg.pwm_period  <= lcpr_pkg::PWM_PERIOD_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                lcpr_pkg::CFG_DECODE_MODE: cfg_reg.decode_mode <= cfg_wdata;
                lcpr_pkg::CFG_INTENSITY:   cfg_reg.intensity   <= cfg_wdata[3:0];
                lcpr_pkg::CFG_SCAN_LIMIT:  cfg_reg.scan_limit  <= cfg_wdata;
                lcpr_pkg::CFG_PWM_PERIOD:  cfg_reg.pwm_period  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lcpr_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .mem_req  (mem_req),
        .rd_level (rd_level),
        .acc_ctl  (acc_ctl),
        .acc_bits (acc_bits),
        .phase    (phase),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lcpr_level_mem u_mem (
        .aclk     (aclk),
        .req      (mem_req),
        .rd_level (rd_level)
    );

    lcpr_bit_acc u_acc (
        .aclk  (aclk),
        .ctl   (acc_ctl),
        .phase (phase),
        .level (rd_level),
        .bits  (acc_bits)
    );

endmodule

### design/lcpr_checker.sv
// Port-level checker for the LED cube PWM refresh engine, bound to the top level.
module lcpr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [1:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lcpr_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    // Output stays valid while stalled
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A request that yields results closes the input side next cycle
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != lcpr_pkg::OP_WRITE |=> !s_tready)
        else $error("s_tready high while a request is in progress");

    // A read answer is a single transaction with empty command fields
    a_read_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == lcpr_pkg::KIND_READ |-> m_tlast && m_tdata[12:0] == 13'd0)
        else $error("malformed read answer");

    // The last command word of a run also closes a latch group
    a_last_is_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tuser == lcpr_pkg::KIND_CMD |-> m_tdata[12])
        else $error("last command word without frame_end");

    // Nothing leaves the block right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind led_cube_pwm_refresh lcpr_checker u_lcpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### verif/led_cube_pwm_refresh_tb.sv
// Self-checking stream testbench for the LED cube PWM refresh engine.
module led_cube_pwm_refresh_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SETTLE_CYCLES = 32;
    localparam int          LONG_HOLD     = 600;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          REQ_BITS      = 17;

    typedef struct packed {
        lcpr_pkg::op_t op;
        logic [2:0]    depth;
        logic [2:0]    row;
        logic [2:0]    col;
        logic [7:0]    level;
    } cube_req_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic       frame_end;
        logic       is_lit;
        logic       last;
    } chain_word_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_RUNS} sink_mode_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [lcpr_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [lcpr_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;
    logic                           cfg_wen   = 1'b0;
    logic [lcpr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lcpr_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

    // Mirror of the block state used for prediction
    logic [7:0]     level_mirror [lcpr_pkg::STORE_DEPTH] = '{default: 8'h00};
    logic [7:0]     phase_mirror = 8'h00;
    lcpr_pkg::cfg_t cfg_mirror = '{lcpr_pkg::DECODE_MODE_RST, lcpr_pkg::INTENSITY_RST,
                                   lcpr_pkg::SCAN_LIMIT_RST, lcpr_pkg::PWM_PERIOD_RST};

    cube_req_t   pending_reqs[$];
    chain_word_t chain_words_due[$];
    logic [8:0]  written_cells[$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Sender and receiver pacing
    cube_req_t   in_flight;
    bit          tx_bursty = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    sink_mode_t  rx_mode = RX_ALWAYS;
    int          rx_run = 0;
    bit          rx_level = 1'b1;
    int          hold_cycles = 0;
    bit          long_hold_req = 1'b0;
    chain_word_t seen_word;
    chain_word_t due_word;

    led_cube_pwm_refresh dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [2:0] depth, [5:3] row, [8:6] column, [16:9] level
        .s_tuser   (s_tuser),   // [1:0] op
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [3:0] address, [11:4] data, [12] frame_end, [13] is_lit
        .m_tuser   (m_tuser),   // [0] kind
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Work out the chain words one accepted request causes and advance the mirror
    function automatic void compute_chain_words(input cube_req_t r);
        chain_word_t w;
        logic [7:0]  data;
        logic [8:0]  nxt;
        logic [7:0]  setup_vals [4];
        int          dep;
        w = '0;
        case (r.op)
            lcpr_pkg::OP_WRITE: level_mirror[{r.depth, r.row, r.col}] = r.level;
            lcpr_pkg::OP_READ: begin
                w.kind   = lcpr_pkg::KIND_READ;
                w.is_lit = (level_mirror[{r.depth, r.row, r.col}] != 8'h00);
                w.last   = 1'b1;
                chain_words_due.push_back(w);
            end
            lcpr_pkg::OP_REFRESH: begin
                for (int row = 0; row < lcpr_pkg::CUBE_SIDE; row++) begin
                    for (int j = 0; j < lcpr_pkg::CHAIN_MODULES; j++) begin
                        dep = lcpr_pkg::CHAIN_MODULES - 1 - j;
                        data = 8'h00;
                        for (int col = 0; col < lcpr_pkg::CUBE_SIDE; col++)
                            if (phase_mirror < level_mirror[dep * 64 + row * 8 + col])
                                data[col] = 1'b1;
                        w.kind        = lcpr_pkg::KIND_CMD;
                        w.reg_address = 4'(row + 1);
                        w.reg_data    = data;
                        w.frame_end   = (j == lcpr_pkg::CHAIN_MODULES - 1);
                        w.is_lit      = 1'b0;
                        w.last        = (row == lcpr_pkg::CUBE_SIDE - 1)
                                        && (j == lcpr_pkg::CHAIN_MODULES - 1);
                        chain_words_due.push_back(w);
                    end
                end
                // Advance the phase; a lowered or zero period wraps it at once
                nxt = {1'b0, phase_mirror} + 9'd1;
                phase_mirror = (nxt >= {1'b0, cfg_mirror.pwm_period}) ? 8'h00 : nxt[7:0];
            end
            default: begin
                setup_vals[0] = cfg_mirror.decode_mode;
                setup_vals[1] = {4'h0, cfg_mirror.intensity};
                setup_vals[2] = cfg_mirror.scan_limit;
                setup_vals[3] = lcpr_pkg::NORMAL_OPERATION;
                for (int g = 0; g < 4; g++) begin
                    for (int j = 0; j < lcpr_pkg::CHAIN_MODULES; j++) begin
                        w.kind        = lcpr_pkg::KIND_CMD;
                        w.reg_address = lcpr_pkg::ADDR_FIRST_SETUP + 4'(g);
                        w.reg_data    = setup_vals[g];
                        w.frame_end   = (j == lcpr_pkg::CHAIN_MODULES - 1);
                        w.is_lit      = 1'b0;
                        w.last        = (g == 3) && (j == lcpr_pkg::CHAIN_MODULES - 1);
                        chain_words_due.push_back(w);
                    end
                end
            end
        endcase
    endfunction

    function automatic cube_req_t make_req(input lcpr_pkg::op_t op, input int x, input int y,
                                           input int z, input int lvl);
        cube_req_t r;
        r.op    = op;
        r.depth = 3'(x);
        r.row   = 3'(y);
        r.col   = 3'(z);
        r.level = 8'(lvl);
        return r;
    endfunction

    // Random request: mostly writes and reads, reads often aimed at written LEDs
    function automatic cube_req_t random_req();
        cube_req_t r;
        int        dice;
        int        pick;
        r.depth = 3'($urandom);
        r.row   = 3'($urandom);
        r.col   = 3'($urandom);
        r.level = 8'($urandom);
        dice = $urandom_range(0, 99);
        if (dice < 48) begin
            r.op = lcpr_pkg::OP_WRITE;
            pick = $urandom_range(0, 9);
            // Keep most levels near the phase range so the PWM bits toggle
            if (pick < 5)
                r.level = 8'($urandom_range(0, 12));
            else if (pick < 7)
                r.level = pick[0] ? 8'd10 : 8'd0;
            written_cells.push_back({r.depth, r.row, r.col});
            if (written_cells.size() > 24)
                void'(written_cells.pop_front());
        end else if (dice < 80) begin
            r.op = lcpr_pkg::OP_READ;
            if (written_cells.size() != 0 && $urandom_range(0, 2) != 0) begin
                pick = $urandom_range(0, written_cells.size() - 1);
                {r.depth, r.row, r.col} = written_cells[pick];
            end
        end else if (dice < 92) begin
            r.op = lcpr_pkg::OP_REFRESH;
        end else begin
            r.op = lcpr_pkg::OP_INIT;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Write all four registers plus one unused index, then release the port
    task automatic program_regs(input logic [7:0] dm, input logic [7:0] inten,
                                input logic [7:0] sl, input logic [7:0] per);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= lcpr_pkg::CFG_DECODE_MODE;
        cfg_wdata <= dm;
        @(posedge aclk);
        cfg_index <= lcpr_pkg::CFG_INTENSITY;
        cfg_wdata <= inten;
        @(posedge aclk);
        cfg_index <= lcpr_pkg::CFG_SCAN_LIMIT;
        cfg_wdata <= sl;
        @(posedge aclk);
        cfg_index <= lcpr_pkg::CFG_PWM_PERIOD;
        cfg_wdata <= per;
        @(posedge aclk);
        cfg_index <= lcpr_pkg::CFG_PWM_PERIOD + 3'($urandom_range(1, 4));
        cfg_wdata <= 8'($urandom);
        @(posedge aclk);
        cfg_wen <= 1'b0;
        cfg_mirror.decode_mode = dm;
        cfg_mirror.intensity   = inten[3:0];
        cfg_mirror.scan_limit  = sl;
        cfg_mirror.pwm_period  = per;
    endtask

    // Hold until every request is taken and every chain word has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || chain_words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Driver: present requests from the queue, in bursts when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                compute_chain_words(in_flight);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    in_flight = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(lcpr_pkg::S_TDATA_W - REQ_BITS){1'b0}},
                                 in_flight.level, in_flight.col,
                                 in_flight.row, in_flight.depth};
                    s_tuser  <= in_flight.op;
                    if (tx_bursty) begin
                        if (burst_left <= 1) begin
                            burst_left = $urandom_range(1, 10);
                            gap_left   = $urandom_range(1, 8);
                        end else begin
                            burst_left--;
                        end
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall on its own pattern, with an occasional long hold-off
    always @(posedge aclk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cycles   = LONG_HOLD;
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (rx_run == 0) begin
                        rx_level = !rx_level;
                        rx_run   = $urandom_range(1, 6);
                    end else begin
                        rx_run--;
                    end
                    m_tready <= rx_level;
                end
            endcase
        end
    end

    // Monitor: compare each result transaction with the oldest expected word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_word.kind        = m_tuser;
            seen_word.reg_address = m_tdata[3:0];
            seen_word.reg_data    = m_tdata[11:4];
            seen_word.frame_end   = m_tdata[12];
            seen_word.is_lit      = m_tdata[13];
            seen_word.last        = m_tlast;
            if (chain_words_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, seen_word);
                mismatch_count++;
            end else begin
                due_word = chain_words_due.pop_front();
                check_field("kind", due_word.kind, seen_word.kind);
                check_field("reg_address", due_word.reg_address, seen_word.reg_address);
                check_field("reg_data", due_word.reg_data, seen_word.reg_data);
                check_field("frame_end", due_word.frame_end, seen_word.frame_end);
                check_field("is_lit", due_word.is_lit, seen_word.is_lit);
                check_field("last", due_word.last, seen_word.last);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("led_cube_pwm_refresh test failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] period_plan [6];
        period_plan = '{8'd255, 8'd3, 8'd0, 8'd1, 8'($urandom_range(2, 40)), 8'd10};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under reset configuration, no idling on either side
        pending_reqs.push_back(make_req(lcpr_pkg::OP_WRITE, 0, 0, 0, 255));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_WRITE, 7, 7, 7, 1));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_WRITE, 7, 0, 7, 10));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_WRITE, 0, 7, 0, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_WRITE, 3, 5, 2, 128));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_WRITE, 6, 1, 4, 10));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_WRITE, 6, 1, 4, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_WRITE, 5, 6, 1, 2));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_READ, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_READ, 7, 7, 7, 255));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_READ, 6, 1, 4, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_READ, 2, 2, 2, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_READ, 0, 7, 0, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_INIT, 7, 7, 7, 255));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_REFRESH, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_REFRESH, 7, 7, 7, 255));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_READ, 3, 5, 2, 0));
        wait_drained();

        // Period lowered below the current phase, extreme register values
        tx_bursty = 1'b1;
        rx_mode   = RX_RANDOM;
        program_regs(8'hFF, 8'hFF, 8'h00, 8'd1);
        pending_reqs.push_back(make_req(lcpr_pkg::OP_INIT, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_REFRESH, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_REFRESH, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_WRITE, 4, 3, 6, 255));
        pending_reqs.push_back(make_req(lcpr_pkg::OP_READ, 4, 3, 6, 0));
        wait_drained();

        // Random phases, each under its own configuration and pacing
        for (int p = 0; p < 6; p++) begin
            program_regs((p == 0) ? 8'h00 : 8'($urandom),
                         (p == 0) ? 8'h00 : 8'($urandom),
                         (p == 0) ? 8'hFF : 8'($urandom),
                         period_plan[p]);
            rx_mode   = sink_mode_t'(p % 3);
            tx_bursty = (p != 3);
            if (p == 2)
                long_hold_req = 1'b1;
            pending_reqs.push_back(make_req(lcpr_pkg::OP_REFRESH, 0, 0, 0, 0));
            repeat (32) pending_reqs.push_back(random_req());
            wait_drained();
        end

        if (chain_words_due.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("led_cube_pwm_refresh test passed");
        else
            $display("led_cube_pwm_refresh test failed");
        $finish;
    end

endmodule
